@@ rtl/longest_common_substring_top_defines.svh @@
// assertion macros for the longest common substring block
`ifndef LONGEST_COMMON_SUBSTRING_TOP_DEFINES_SVH
`define LONGEST_COMMON_SUBSTRING_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lcs_pkg.sv @@
`timescale 1ns / 1ps

package lcs_pkg;

    // fixed field widths
    localparam int ACTION_W = 2;
    localparam int SYM_PORT_W = 8;
    localparam int RUN_W = 9;
    localparam logic [RUN_W-1:0] RUN_MAX = 9'd511;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PROCESS = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REPORT  = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

    // broadcast command from the controller to every cell
    typedef struct packed {
        logic append;
        logic process;
        logic clear;
    } cell_cmd_t;

endpackage

@@ rtl/longest_common_substring_top.sv @@
`timescale 1ns / 1ps
// append and second-string transactions are taken one per cycle while in_stall is low
// a report transaction stalls input until its result is loaded, once the best run
// has rippled through the cell chain one cell per cycle after the last second-string
// transaction and any held result is taken; the result shows the cycle after loading
// reset (asynchronous, active low) empties the store and clears best and overflow

module longest_common_substring_top #(
    parameter int MAX_LEN = 256,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [lcs_pkg::ACTION_W-1:0]     action,
    input  logic [lcs_pkg::SYM_PORT_W-1:0]   symbol,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [lcs_pkg::RUN_W-1:0]        longest,
    output logic                             overflow
);
    import lcs_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int CELL_SYM_W = (SYMBOL_BITS < SYM_PORT_W) ? SYMBOL_BITS : SYM_PORT_W;

    cell_cmd_t        cmd;
    logic [LEN_W-1:0] length;
    logic [RUN_W-1:0] run_chain [0:MAX_LEN];
    logic [RUN_W-1:0] best_chain [0:MAX_LEN];

    // chain head sees an empty neighbour
    assign run_chain[0] = '0;
    assign best_chain[0] = '0;

    lcs_ctrl #(
        .MAX_LEN(MAX_LEN),
        .LEN_W(LEN_W)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .longest(longest),
        .overflow(overflow),
        .chain_best(best_chain[MAX_LEN]),
        .cmd(cmd),
        .length(length)
    );

    // one cell per stored symbol
    for (genvar k = 0; k < MAX_LEN; k++)
    begin : g_cell
        lcs_cell #(
            .INDEX(k),
            .LEN_W(LEN_W),
            .SYM_W(CELL_SYM_W)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .cmd(cmd),
            .length(length),
            .symbol(symbol[CELL_SYM_W-1:0]),
            .left_run(run_chain[k]),
            .left_best(best_chain[k]),
            .run(run_chain[k+1]),
            .best(best_chain[k+1])
        );
    end

endmodule

@@ rtl/lcs_cell.sv @@
`timescale 1ns / 1ps

module lcs_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 9,
    parameter int SYM_W = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lcs_pkg::cell_cmd_t       cmd,
    input  logic [LEN_W-1:0]         length,
    input  logic [SYM_W-1:0]         symbol,
    input  logic [lcs_pkg::RUN_W-1:0] left_run,
    input  logic [lcs_pkg::RUN_W-1:0] left_best,
    output logic [lcs_pkg::RUN_W-1:0] run,
    output logic [lcs_pkg::RUN_W-1:0] best
);
    import lcs_pkg::*;

    logic             occupied_reg, occupied_next;
    logic [SYM_W-1:0] sym_reg;
    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] best_reg, best_next;
    logic             write_en;
    logic             update_en;
    logic [RUN_W-1:0] run_next;
    logic [RUN_W-1:0] cand;

    // this cell takes the next appended symbol
    assign write_en = cmd.append && (length == LEN_W'(INDEX));
    assign update_en = cmd.process && occupied_reg;

    // diagonal run: extend the left neighbour's previous run on a match
    always_comb
    begin
        run_next = '0;
        if (sym_reg == symbol)
        begin
            run_next = (left_run >= RUN_MAX) ? RUN_MAX : left_run + RUN_W'(1);
        end
    end

    // running best ripples down the chain one cell per cycle
    always_comb
    begin
        cand = update_en ? run_next : '0;
        best_next = best_reg;
        if (left_best > best_next)
        begin
            best_next = left_best;
        end
        if (cand > best_next)
        begin
            best_next = cand;
        end
        occupied_next = occupied_reg;
        if (cmd.clear)
        begin
            occupied_next = 1'b0;
            best_next = '0;
        end
        else if (write_en)
        begin
            occupied_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            occupied_reg <= occupied_next;
            best_reg <= best_next;
        end
    end

    // stored symbol and run length
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            sym_reg <= symbol;
            run_reg <= '0;
        end
        else if (update_en)
        begin
            run_reg <= run_next;
        end
    end

    assign run = run_reg;
    assign best = best_reg;

endmodule

@@ rtl/lcs_ctrl.sv @@
`timescale 1ns / 1ps

module lcs_ctrl #(
    parameter int MAX_LEN = 256,
    parameter int LEN_W = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lcs_pkg::ACTION_W-1:0] action,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lcs_pkg::RUN_W-1:0]    longest,
    output logic                         overflow,
    input  logic [lcs_pkg::RUN_W-1:0]    chain_best,
    output lcs_pkg::cell_cmd_t           cmd,
    output logic [LEN_W-1:0]             length
);
    import lcs_pkg::*;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             out_valid_reg, out_valid_next;
    logic [RUN_W-1:0] longest_reg;
    logic             overflow_reg;
    logic             accept;
    logic             full;
    logic             load;
    logic             is_append, is_process, is_report;

    assign in_stall = (state_reg != S_RUN);
    assign accept = in_valid && !in_stall;
    assign full = (length_reg == LEN_W'(MAX_LEN));

    // action decode
    always_comb
    begin
        is_append = 1'b0;
        is_process = 1'b0;
        is_report = 1'b0;
        unique case (action)
            ACT_APPEND:  is_append = 1'b1;
            ACT_PROCESS: is_process = 1'b1;
            ACT_REPORT:  is_report = 1'b1;
            default:     ;
        endcase
    end

    // result loads once the best value has reached the end of the chain and any held result has been taken
    assign load = (state_reg == S_DRAIN) && (count_reg == '0)
                  && (!out_valid_reg || !out_stall);

    assign cmd.append = accept && is_append && !full;
    assign cmd.process = accept && is_process;
    assign cmd.clear = load;

    // next state, length, drain counter and flags
    always_comb
    begin
        state_next = state_reg;
        length_next = length_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        unique case (state_reg)
            S_RUN:
            begin
                if (accept && is_report)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (load)
                begin
                    state_next = S_RUN;
                end
            end
            default: state_next = S_RUN;
        endcase
        if (cmd.append)
        begin
            length_next = length_reg + LEN_W'(1);
        end
        if (accept && is_append && full)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.process)
        begin
            count_next = LEN_W'(MAX_LEN - 1);
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - LEN_W'(1);
        end
        if (load)
        begin
            length_next = '0;
            ovf_next = 1'b0;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            length_reg <= '0;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            length_reg <= length_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            longest_reg <= chain_best;
            overflow_reg <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign longest = longest_reg;
    assign overflow = overflow_reg;
    assign length = length_reg;

endmodule

@@ rtl/lcs_checker.sv @@
`timescale 1ns / 1ps
`include "longest_common_substring_top_defines.svh"

module lcs_checker #(
    parameter int MAX_LEN = 256
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [lcs_pkg::ACTION_W-1:0]   action,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [lcs_pkg::RUN_W-1:0]      longest,
    input logic                           overflow
);
    import lcs_pkg::*;

    localparam int LIMIT = (MAX_LEN < 511) ? MAX_LEN : 511;

    // a stalled result holds
    `LCS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(longest) && $stable(overflow), "stalled result changed")

    // a report transaction blocks the input until its result is loaded
    `LCS_ASSERT_NXT(a_report_stalls, in_valid && !in_stall && (action == ACT_REPORT), in_stall, "input not stalled after report")

    // a new result only comes out of the report wait
    `LCS_ASSERT_IMP(a_result_source, $rose(out_valid), $past(in_stall), "result without report")

    // a common substring never exceeds the store
    `LCS_ASSERT_IMP(a_longest_range, out_valid, longest <= RUN_W'(LIMIT), "longest out of range")

endmodule

bind longest_common_substring_top lcs_checker #(.MAX_LEN(MAX_LEN)) u_lcs_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .longest(longest),
    .overflow(overflow)
);
